FILE: hw/rtl/cptm_pkg.sv
package cptm_pkg;

    localparam int CFG_DATA_W  = 32;
    localparam int CFG_INDEX_W = 2;
    localparam int CH_FIELD_W  = 3;
    localparam int COUNT_W     = 16;
    localparam int TIME_W      = 32;
    localparam int TMO_W       = 16;
    localparam int VALUE_W     = 32;

    // The frequency is clock / (delta * 100), with 100 < 2**7.
    localparam int FREQ_SCALE  = 100;
    localparam int DIVIDEND_W  = 32;
    localparam int DIVISOR_W   = COUNT_W + 7;
    localparam int DIV_STEP_W  = $clog2(DIVIDEND_W);

    localparam logic [CFG_DATA_W-1:0] CLOCK_HZ_RESET    = 32'd84000000;
    localparam logic [TMO_W-1:0]      FAN_TMO_RESET     = 16'd100;
    localparam logic [TMO_W-1:0]      PULSE_TMO_RESET   = 16'd21;

    localparam logic KIND_CAPTURE = 1'b0;
    localparam logic KIND_READ    = 1'b1;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_CLOCK_HZ  = 2'd0,
        REG_FAN_TMO   = 2'd1,
        REG_PULSE_TMO = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic                  kind;
        logic [CH_FIELD_W-1:0] channel;
        logic [COUNT_W-1:0]    capture_count;
        logic [TIME_W-1:0]     now_ms;
    } item_t;

    typedef struct packed {
        logic [VALUE_W-1:0] measured_value;
        logic               recent;
        logic               value_updated;
    } result_t;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] clock_hz;
        logic [TMO_W-1:0]      fan_timeout_ms;
        logic [TMO_W-1:0]      pulse_timeout_ms;
    } cfg_t;

    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        logic [DIVISOR_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic                  done;
        logic [DIVIDEND_W-1:0] quotient;
    } div_rsp_t;

endpackage

FILE: hw/rtl/cptm_stream_if.sv
interface cptm_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: hw/rtl/cptm_cfg.sv
module cptm_cfg (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              we,
    input  logic [cptm_pkg::CFG_INDEX_W-1:0]  index,
    input  logic [cptm_pkg::CFG_DATA_W-1:0]   data,
    output cptm_pkg::cfg_t                    cfg
);
    import cptm_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (we)
        begin
            unique case (index)
                REG_CLOCK_HZ:  cfg_next.clock_hz         = data;
                REG_FAN_TMO:   cfg_next.fan_timeout_ms   = data[TMO_W-1:0];
                REG_PULSE_TMO: cfg_next.pulse_timeout_ms = data[TMO_W-1:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.clock_hz         <= CLOCK_HZ_RESET;
            cfg_reg.fan_timeout_ms   <= FAN_TMO_RESET;
            cfg_reg.pulse_timeout_ms <= PULSE_TMO_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: hw/rtl/cptm_div.sv
module cptm_div (
    input  logic                clk,
    input  logic                rst_n,
    input  cptm_pkg::div_req_t  req,
    output cptm_pkg::div_rsp_t  rsp
);
    import cptm_pkg::*;

    localparam logic [DIV_STEP_W-1:0] STEP_LAST = DIV_STEP_W'(DIVIDEND_W - 1);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [DIV_STEP_W-1:0] step_reg, step_next;
    logic [DIVIDEND_W-1:0] dvd_reg, dvd_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVISOR_W-1:0]  dvs_reg, dvs_next;

    logic [DIVISOR_W:0]    shifted;
    logic [DIVISOR_W+1:0]  diff;
    logic                  fits;

    // One quotient bit per cycle: the dividend shifts out at the top while
    // quotient bits shift in at the bottom of the same register.
    assign shifted = {rem_reg, dvd_reg[DIVIDEND_W-1]};
    assign diff    = {1'b0, shifted} - {2'b00, dvs_reg};
    assign fits    = !diff[DIVISOR_W+1];

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            dvd_next  = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            dvd_next  = {dvd_reg[DIVIDEND_W-2:0], fits};
            rem_next  = fits ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = dvd_reg;

endmodule

FILE: hw/rtl/capture_pulse_and_tach_meter.sv
// Capture pulse-width and fan tachometer meter.
// The item channel takes capture edges (kind 0) and status reads (kind 1) for
// one channel each; every item gives exactly one transfer on the result channel.
// Edges pair up per channel: pulse channels store a positive second minus first
// count, the fan channel stores clock_hz / (delta * 100) for nonzero delta, by a
// bit-serial restoring divider that retires one quotient bit per cycle.
// One item is in work at a time. A read, a first edge or a pulse edge passes
// through the EXEC and DONE states before its result is loaded into the output
// register; a fan measurement also waits in DIV for the 32 steps of the divider.
// The input is ready again in the cycle after the result is loaded into the
// output register, so a new item is taken while the previous result still
// waits for its transfer.
// If the receiver stalls, a finished result waits in the output register and
// the following item waits, done, until that register is free.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at the next
// edge and are meant for idle periods only.
// Reset clears every channel (disarmed, counts, stamps and values zero) and
// loads the configuration defaults.
module capture_pulse_and_tach_meter #(
    parameter int NUM_CHANNELS  = 5,
    parameter int FAN_CHANNEL   = 4,
    parameter int COUNTER_WIDTH = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    cptm_stream_if.sink                       item,
    cptm_stream_if.source                     result,
    input  logic                              cfg_we,
    input  logic [cptm_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [cptm_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import cptm_pkg::*;

    localparam int IDX_W = $clog2(NUM_CHANNELS);
    localparam int EXT_W = (IDX_W > CH_FIELD_W) ? IDX_W : CH_FIELD_W;
    localparam logic [COUNT_W-1:0] CNT_MASK = (COUNTER_WIDTH >= COUNT_W) ?
        {COUNT_W{1'b1}} : COUNT_W'((64'd1 << COUNTER_WIDTH) - 64'd1);
    localparam bit FAN_PRESENT = (FAN_CHANNEL < NUM_CHANNELS);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_DIV  = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

    state_t   state_reg, state_next;
    item_t    it_reg, it_next;
    logic     upd_reg, upd_next;
    logic     res_valid_reg, res_valid_next;
    result_t  res_data_reg, res_data_next;

    logic                  armed_reg [NUM_CHANNELS];
    logic [COUNT_W-1:0]    first_reg [NUM_CHANNELS];
    logic [TIME_W-1:0]     last_reg  [NUM_CHANNELS];
    logic [VALUE_W-1:0]    value_reg [NUM_CHANNELS];

    cfg_t      cfg;
    div_req_t  div_req;
    div_rsp_t  div_rsp;

    logic [EXT_W-1:0]   ch_ext;
    logic [IDX_W-1:0]   idx;
    logic               in_range;
    logic               is_fan;
    logic               armed_rd;
    logic [COUNT_W-1:0] first_rd;
    logic [TIME_W-1:0]  last_rd;
    logic [VALUE_W-1:0] value_rd;
    logic [COUNT_W-1:0] cnt_m;
    logic [COUNT_W-1:0] delta;
    logic [TMO_W-1:0]   tmo;
    logic [TIME_W-1:0]  limit;
    logic               recent;

    logic set_first, clr_armed, stamp, pulse_wr, fan_wr, res_load;

    cptm_cfg u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (cfg_we),
        .index (cfg_index),
        .data  (cfg_data),
        .cfg   (cfg)
    );

    cptm_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign ch_ext   = EXT_W'(it_reg.channel);
    assign idx      = ch_ext[IDX_W-1:0];
    assign in_range = int'(it_reg.channel) < NUM_CHANNELS;
    assign is_fan   = FAN_PRESENT && (int'(it_reg.channel) == FAN_CHANNEL);

    // Reads past the last channel only happen when in_range is low, and then
    // the read data is masked off.
    assign armed_rd = armed_reg[idx];
    assign first_rd = first_reg[idx];
    assign last_rd  = last_reg[idx];
    assign value_rd = value_reg[idx];

    assign cnt_m  = it_reg.capture_count & CNT_MASK;
    assign delta  = (cnt_m - first_rd) & CNT_MASK;
    assign tmo    = is_fan ? cfg.fan_timeout_ms : cfg.pulse_timeout_ms;
    assign limit  = last_rd + TIME_W'(tmo);
    assign recent = (it_reg.now_ms <= limit);

    assign item.ready = (state_reg == S_IDLE);
    assign it_next    = ((state_reg == S_IDLE) && item.valid) ? item.data : it_reg;

    always_comb
    begin
        state_next       = state_reg;
        upd_next         = upd_reg;
        set_first        = 1'b0;
        clr_armed        = 1'b0;
        stamp            = 1'b0;
        pulse_wr         = 1'b0;
        fan_wr           = 1'b0;
        res_load         = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = cfg.clock_hz;
        // floor(floor(c / d) / 100) equals floor(c / (100 * d)).
        div_req.divisor  = DIVISOR_W'(delta) * DIVISOR_W'(FREQ_SCALE);

        unique case (state_reg)
            S_IDLE:
            begin
                if (item.valid)
                begin
                    state_next = S_EXEC;
                    upd_next   = 1'b0;
                end
            end
            S_EXEC:
            begin
                state_next = S_DONE;
                if (in_range && (it_reg.kind == KIND_CAPTURE))
                begin
                    stamp = 1'b1;
                    if (!armed_rd)
                    begin
                        set_first = 1'b1;
                    end
                    else
                    begin
                        clr_armed = 1'b1;
                        if (is_fan)
                        begin
                            if (delta != '0)
                            begin
                                div_req.start = 1'b1;
                                state_next    = S_DIV;
                            end
                        end
                        else if (cnt_m > first_rd)
                        begin
                            pulse_wr = 1'b1;
                            upd_next = 1'b1;
                        end
                    end
                end
            end
            S_DIV:
            begin
                if (div_rsp.done)
                begin
                    fan_wr     = 1'b1;
                    upd_next   = 1'b1;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!res_valid_reg || result.ready)
                begin
                    res_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        res_data_next  = res_data_reg;
        if (res_load)
        begin
            res_valid_next               = 1'b1;
            res_data_next.measured_value = in_range ? value_rd : '0;
            res_data_next.recent         = in_range && recent;
            res_data_next.value_updated  = upd_reg;
        end
        else if (result.ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            upd_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            upd_reg       <= upd_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        it_reg       <= it_next;
        res_data_reg <= res_data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                armed_reg[i] <= 1'b0;
                first_reg[i] <= '0;
                last_reg[i]  <= '0;
                value_reg[i] <= '0;
            end
        end
        else
        begin
            if (set_first)
            begin
                first_reg[idx] <= cnt_m;
                armed_reg[idx] <= 1'b1;
            end
            if (clr_armed)
            begin
                armed_reg[idx] <= 1'b0;
            end
            if (stamp)
            begin
                last_reg[idx] <= it_reg.now_ms;
            end
            if (pulse_wr)
            begin
                value_reg[idx] <= VALUE_W'(cnt_m - first_rd);
            end
            if (fan_wr)
            begin
                value_reg[idx] <= VALUE_W'(div_rsp.quotient);
            end
        end
    end

    assign result.valid = res_valid_reg;
    assign result.data  = res_data_reg;

endmodule

FILE: hw/rtl/cptm_chk.sv
module cptm_chk (
    input logic               clk,
    input logic               rst_n,
    input logic               item_valid,
    input logic               item_ready,
    input logic               res_valid,
    input logic               res_ready,
    input cptm_pkg::result_t  res_data
);
    import cptm_pkg::*;

    // Only one item is in work, so the input closes right after a transfer.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && item_ready) |=> !item_ready)
        else $error("item accepted while another is in work");

    // A new result is only loaded while the block is busy with an item.
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(!item_ready))
        else $error("result appeared while the block was idle");

    a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |=> res_valid)
        else $error("result dropped before its transfer");

    a_data_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |=> $stable(res_data))
        else $error("stalled result changed");

endmodule

bind capture_pulse_and_tach_meter cptm_chk u_cptm_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item.valid),
    .item_ready (item.ready),
    .res_valid  (result.valid),
    .res_ready  (result.ready),
    .res_data   (result.data)
);

FILE: verif/capture_pulse_and_tach_meter_tb.sv
module capture_pulse_and_tach_meter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cptm_pkg::*;

    localparam int NUM_CH         = 5;
    localparam int FAN_CH         = 4;
    localparam int SETTLE_CYCLES  = 40;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_ITEMS    = 150;

    // Index past the end of the register map; writes to it must do nothing.
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;

    logic clk;
    logic rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    cptm_stream_if #(.T(item_t))   item_if ();
    cptm_stream_if #(.T(result_t)) result_if ();

    capture_pulse_and_tach_meter #(
        .NUM_CHANNELS  (NUM_CH),
        .FAN_CHANNEL   (FAN_CH),
        .COUNTER_WIDTH (COUNT_W)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item_if),
        .result    (result_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Predicted per-channel state and register copies.
    logic               arm_flag    [NUM_CH];
    logic [COUNT_W-1:0] start_count [NUM_CH];
    logic [TIME_W-1:0]  edge_stamp  [NUM_CH];
    logic [VALUE_W-1:0] held_value  [NUM_CH];
    logic [CFG_DATA_W-1:0] clk_hz_m;
    logic [TMO_W-1:0]      fan_tmo_m;
    logic [TMO_W-1:0]      pulse_tmo_m;

    result_t pending_readings [$];

    int unsigned src_idle_pct;
    int unsigned snk_stall_pct;
    logic [TIME_W-1:0] tick_ms;
    int unsigned idle_cycles;
    int unsigned fail_cnt;
    int unsigned n_items;
    int unsigned n_results;
    int unsigned n_fan_meas;
    int unsigned n_cfg_writes;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic result_t meter_predict(item_t it);
        result_t            r;
        logic [COUNT_W-1:0] delta;
        logic [TMO_W-1:0]   tmo;
        logic [TIME_W-1:0]  limit;
        int unsigned        ch;
        r  = '0;
        ch = it.channel;
        if (ch >= NUM_CH)
        begin
            return r;
        end
        if (it.kind == KIND_CAPTURE)
        begin
            if (!arm_flag[ch])
            begin
                start_count[ch] = it.capture_count;
                arm_flag[ch]    = 1'b1;
            end
            else
            begin
                if (ch == FAN_CH)
                begin
                    delta = it.capture_count - start_count[ch];
                    if (delta != '0)
                    begin
                        held_value[ch]  = (clk_hz_m / delta) / FREQ_SCALE;
                        r.value_updated = 1'b1;
                        n_fan_meas++;
                    end
                end
                else if (it.capture_count > start_count[ch])
                begin
                    held_value[ch]  = it.capture_count - start_count[ch];
                    r.value_updated = 1'b1;
                end
                arm_flag[ch] = 1'b0;
            end
            edge_stamp[ch] = it.now_ms;
        end
        tmo   = (ch == FAN_CH) ? fan_tmo_m : pulse_tmo_m;
        // The window end wraps at 32 bits, just like the tick counter.
        limit = edge_stamp[ch] + tmo;
        r.measured_value = held_value[ch];
        r.recent         = (it.now_ms <= limit);
        return r;
    endfunction

    function automatic item_t random_item();
        item_t       it;
        int unsigned ch;
        int unsigned pick;
        logic [TMO_W-1:0] tmo;
        pick = $urandom_range(0, 99);
        ch   = (pick < 8) ? $urandom_range(NUM_CH, 7) : $urandom_range(0, NUM_CH - 1);
        it.channel = CH_FIELD_W'(ch);
        it.kind    = ($urandom_range(0, 99) < 25) ? KIND_READ : KIND_CAPTURE;
        tick_ms    = tick_ms + $urandom_range(0, 12);
        pick = $urandom_range(0, 99);
        if (ch < NUM_CH && arm_flag[ch] && pick < 70)
        begin
            it.capture_count = COUNT_W'(start_count[ch] + $urandom_range(1, 3000));
        end
        else if (ch < NUM_CH && arm_flag[ch] && pick < 80)
        begin
            it.capture_count = start_count[ch];
        end
        else
        begin
            it.capture_count = COUNT_W'($urandom);
        end
        pick = $urandom_range(0, 99);
        if (pick < 85 || ch >= NUM_CH)
        begin
            it.now_ms = (pick < 95) ? tick_ms : $urandom;
        end
        else if (pick < 95)
        begin
            // Land right on the edge of the recency window.
            tmo = (ch == FAN_CH) ? fan_tmo_m : pulse_tmo_m;
            it.now_ms = edge_stamp[ch] + tmo + $urandom_range(0, 2) - 1;
        end
        else
        begin
            it.now_ms = $urandom;
        end
        return it;
    endfunction

    task automatic send_item(item_t it);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            item_if.valid <= 1'b0;
            @(negedge clk);
        end
        item_if.valid <= 1'b1;
        item_if.data  <= it;
        do
            @(posedge clk);
        while (!item_if.ready);
        pending_readings.push_back(meter_predict(it));
        n_items++;
        @(negedge clk);
    endtask

    task automatic send_edge(int unsigned ch, logic [COUNT_W-1:0] cnt, logic [TIME_W-1:0] now);
        item_t it;
        it.kind          = KIND_CAPTURE;
        it.channel       = CH_FIELD_W'(ch);
        it.capture_count = cnt;
        it.now_ms        = now;
        send_item(it);
    endtask

    task automatic send_read(int unsigned ch, logic [TIME_W-1:0] now);
        item_t it;
        it.kind          = KIND_READ;
        it.channel       = CH_FIELD_W'(ch);
        it.capture_count = COUNT_W'($urandom);
        it.now_ms        = now;
        send_item(it);
    endtask

    task automatic wait_drained(bit settle);
        item_if.valid <= 1'b0;
        while (pending_readings.size() != 0)
            @(posedge clk);
        if (settle)
            repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_CLOCK_HZ:  clk_hz_m    = val;
            REG_FAN_TMO:   fan_tmo_m   = val[TMO_W-1:0];
            REG_PULSE_TMO: pulse_tmo_m = val[TMO_W-1:0];
            default: ;
        endcase
        n_cfg_writes++;
        @(negedge clk);
    endtask

    task automatic test_reset_readout();
        send_read(0, 32'd21);
        send_read(0, 32'd22);
        send_read(FAN_CH, 32'd100);
        send_read(FAN_CH, 32'd101);
        send_read(7, 32'hFFFF_FFFF);
    endtask

    task automatic test_edge_pairing();
        // Widest pulse, then the window boundary on either side.
        send_edge(0, 16'h0000, 32'd1000);
        send_edge(0, 16'hFFFF, 32'd1010);
        send_read(0, 32'd1031);
        send_read(0, 32'd1032);
        // Equal and decreasing pulse pairs keep the old value.
        send_edge(1, 16'd500, 32'd1040);
        send_edge(1, 16'd500, 32'd1041);
        send_edge(1, 16'd700, 32'd1042);
        send_edge(1, 16'd300, 32'd1043);
        // Fan: counter wrap, zero delta, delta of one.
        send_edge(FAN_CH, 16'hFFF0, 32'd2000);
        send_edge(FAN_CH, 16'h0010, 32'd2001);
        send_edge(FAN_CH, 16'd1234, 32'd2002);
        send_edge(FAN_CH, 16'd1234, 32'd2003);
        send_edge(FAN_CH, 16'd0, 32'd2004);
        send_edge(FAN_CH, 16'd1, 32'd2005);
        send_read(FAN_CH, 32'd2105);
        send_read(FAN_CH, 32'd2106);
        // Channels past the last one are ignored.
        send_edge(5, 16'hFFFF, 32'hFFFF_FFFF);
        send_read(6, 32'd0);
        // A stamp near the top of the tick range makes the window wrap.
        send_edge(2, 16'h1234, 32'hFFFF_FFF0);
        send_read(2, 32'hFFFF_FFFF);
        send_read(2, 32'd5);
        send_read(2, 32'd6);
    endtask

    task automatic test_register_extremes();
        wait_drained(1'b1);
        write_reg(REG_CLOCK_HZ, 32'hFFFF_FFFF);
        write_reg(REG_FAN_TMO, 32'd0);
        write_reg(REG_PULSE_TMO, 32'hFFFF);
        write_reg(REG_UNUSED, 32'hDEAD_BEEF);
        send_edge(FAN_CH, 16'd0, 32'd3000);
        send_edge(FAN_CH, 16'd1, 32'd3000);
        send_read(FAN_CH, 32'd3000);
        send_read(FAN_CH, 32'd3001);
        send_edge(FAN_CH, 16'd1, 32'd3002);
        send_edge(FAN_CH, 16'd0, 32'd3003);
        send_read(3, 32'd65535);
        send_read(3, 32'd65536);
        wait_drained(1'b1);
        write_reg(REG_CLOCK_HZ, 32'd1);
        write_reg(REG_FAN_TMO, 32'hFFFF);
        write_reg(REG_PULSE_TMO, 32'd0);
        send_edge(FAN_CH, 16'd10, 32'd4000);
        send_edge(FAN_CH, 16'd11, 32'd4000);
        send_read(FAN_CH, 32'd4000 + 32'd65535);
        send_read(0, 32'd1010);
        send_read(0, 32'd1011);
        wait_drained(1'b1);
        write_reg(REG_CLOCK_HZ, CLOCK_HZ_RESET);
        write_reg(REG_FAN_TMO, 32'(FAN_TMO_RESET));
        write_reg(REG_PULSE_TMO, 32'(PULSE_TMO_RESET));
    endtask

    task automatic random_phase(int unsigned idle, int unsigned stall, bit hold_midway);
        int unsigned pick;
        wait_drained(1'b1);
        pick = $urandom_range(0, 2);
        write_reg(REG_CLOCK_HZ, (pick == 0) ? $urandom :
                                (pick == 1) ? $urandom_range(1, 1000) : CLOCK_HZ_RESET);
        write_reg(REG_FAN_TMO, $urandom_range(0, 1) ? $urandom_range(0, 65535)
                                                    : $urandom_range(0, 150));
        write_reg(REG_PULSE_TMO, $urandom_range(0, 1) ? $urandom_range(0, 65535)
                                                      : $urandom_range(0, 40));
        src_idle_pct  = idle;
        snk_stall_pct = stall;
        for (int i = 0; i < PHASE_ITEMS; i++)
        begin
            if (hold_midway && i == PHASE_ITEMS / 2)
                wait_drained(1'b0);
            send_item(random_item());
        end
    endtask

    task automatic test_random_traffic();
        tick_ms = $urandom_range(0, 5000);
        random_phase(0, 0, 1'b0);
        random_phase(56, 0, 1'b1);
        random_phase(0, 56, 1'b0);
        // Run the last mix across the wrap of the tick counter.
        tick_ms = 32'hFFFF_FF00;
        random_phase(37, 37, 1'b0);
    endtask

    always @(negedge clk)
    begin
        result_if.ready <= ($urandom_range(0, 99) >= snk_stall_pct);
    end

    always @(posedge clk)
    begin : check_results
        result_t exp_r;
        if (rst_n && result_if.valid && result_if.ready)
        begin
            n_results++;
            if (pending_readings.size() == 0)
            begin
                $error("result transfer with no expected result waiting");
                fail_cnt++;
            end
            else
            begin
                exp_r = pending_readings.pop_front();
                if (result_if.data.measured_value !== exp_r.measured_value)
                begin
                    $error("measured_value: expected %0d, got %0d",
                           exp_r.measured_value, result_if.data.measured_value);
                    fail_cnt++;
                end
                if (result_if.data.recent !== exp_r.recent)
                begin
                    $error("recent: expected %0b, got %0b",
                           exp_r.recent, result_if.data.recent);
                    fail_cnt++;
                end
                if (result_if.data.value_updated !== exp_r.value_updated)
                begin
                    $error("value_updated: expected %0b, got %0b",
                           exp_r.value_updated, result_if.data.value_updated);
                    fail_cnt++;
                end
            end
        end
    end

    // Any transfer on either channel counts as progress.
    always @(posedge clk)
    begin
        if ((item_if.valid && item_if.ready) || (result_if.valid && result_if.ready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        item_if.valid   = 1'b0;
        item_if.data    = '0;
        src_idle_pct    = 0;
        snk_stall_pct   = 0;
        n_items         = 0;
        n_fan_meas      = 0;
        n_cfg_writes    = 0;
        tick_ms         = '0;
        clk_hz_m        = CLOCK_HZ_RESET;
        fan_tmo_m       = FAN_TMO_RESET;
        pulse_tmo_m     = PULSE_TMO_RESET;
        for (int i = 0; i < NUM_CH; i++)
        begin
            arm_flag[i]    = 1'b0;
            start_count[i] = '0;
            edge_stamp[i]  = '0;
            held_value[i]  = '0;
        end
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_readout();
        test_edge_pairing();
        test_register_extremes();
        test_random_traffic();

        wait_drained(1'b1);
        if (pending_readings.size() != 0)
        begin
            $error("%0d expected results never arrived", pending_readings.size());
        end
        $display("Sent %0d capture and read items, checked %0d results, %0d fan measurements,",
                 n_items, n_results, n_fan_meas);
        $display("with %0d register writes and four sender/receiver stall mixes.",
                 n_cfg_writes);
        if (fail_cnt == 0 && pending_readings.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
